### rtl/core/svm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svm_pkg
// Shared constants, word types and memory request types of the voice mixer.
// ----------------------------------------------------------------------------
package svm_pkg;

    localparam int VOICE_COUNT         = 8;
    localparam int OUTPUT_RATE         = 11025;
    localparam int SAMPLE_MEMORY_DEPTH = 65536;

    localparam int VOICE_IDX_W   = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int VOICE_CNT_W   = $clog2(VOICE_COUNT + 1);
    localparam int SAMPLE_ADDR_W = $clog2(SAMPLE_MEMORY_DEPTH);
    localparam int MASK_W        = 8;
    localparam int FIELD_VOICES  = (VOICE_COUNT < MASK_W) ? VOICE_COUNT : MASK_W;

    // Step: (rate << 16) / OUTPUT_RATE by a reciprocal multiply and one correction.
    localparam longint MAX_STEP   = (64'd65535 << 16) / OUTPUT_RATE;
    localparam int STEP_W         = $clog2(MAX_STEP + 1);
    localparam int DIVIDEND_W     = 32;
    localparam int STEP_SHIFT     = 16;
    localparam longint STEP_RECIP = (64'd1 << 32) / OUTPUT_RATE;
    localparam int STEP_RECIP_W   = $clog2(STEP_RECIP + 1);
    localparam int STEP_PROD_W    = 16 + STEP_RECIP_W;
    localparam int STEP_REM_W     = $clog2(2 * OUTPUT_RATE);
    localparam int ONE_STEP       = 65536;

    // Audio and lump header constants.
    localparam int SAMPLE_BIAS   = 128;
    localparam int FULL_GAIN     = 127;
    localparam int PAN_MAX       = 254;
    localparam int SAMPLE_SKIP   = 24;
    localparam int COUNT_SKIP    = 32;
    localparam int MIN_LUMP      = 40;
    localparam int HEADER_LEN    = 8;
    localparam int MIN_DATA      = 48;
    localparam int WAVE_TAG      = 3;
    localparam int LUMP_MAX      = 65536;
    localparam int ACC_MAX       = 32767;
    localparam int ACC_MIN       = -32768;

    // Divide-by-127 lanes: reciprocal multiply followed by one correction.
    localparam int DIV_MAG_W     = 22;
    localparam int PROD_W        = DIV_MAG_W + 1;
    localparam int DIV_SHIFT     = 22;
    localparam int RECIP_W       = 16;
    localparam int DIV_RECIP     = (1 << DIV_SHIFT) / FULL_GAIN;
    localparam int QUOT_W        = 16;
    localparam int DIV_REM_W     = DIV_MAG_W + 2;
    localparam int GPROD_W       = 14;

    // Action codes.
    localparam logic [2:0] ACT_WRITE  = 3'd0;
    localparam logic [2:0] ACT_START  = 3'd1;
    localparam logic [2:0] ACT_VOLPAN = 3'd2;
    localparam logic [2:0] ACT_STOP   = 3'd3;
    localparam logic [2:0] ACT_MIX    = 3'd4;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  voice;
        logic [15:0] address;
        logic [7:0]  sample_byte;
        logic [15:0] format_tag;
        logic [15:0] sample_rate;
        logic [31:0] data_length;
        logic [16:0] lump_length;
        logic [6:0]  volume;
        logic [7:0]  separation;
    } command_t;

    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic [MASK_W-1:0]  active_voices;
        logic               start_status;
    } result_t;

    typedef struct packed {
        logic [15:0]       base;
        logic [15:0]       sample_count;
        logic [31:0]       position;
        logic [STEP_W-1:0] step;
        logic [6:0]        left_gain;
        logic [6:0]        right_gain;
    } voice_entry_t;

    typedef struct packed {
        logic                     wr_en;
        logic                     rd_en;
        logic [SAMPLE_ADDR_W-1:0] addr;
        logic [7:0]               wdata;
    } sample_req_t;

    typedef struct packed {
        logic                   wr_en;
        logic                   rd_en;
        logic [VOICE_IDX_W-1:0] addr;
        voice_entry_t           wdata;
    } voice_req_t;

endpackage
`default_nettype wire

### rtl/core/svm_sample_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svm_sample_ram
// Single-port sample byte memory with a registered read.
// ----------------------------------------------------------------------------
module svm_sample_ram
    import svm_pkg::*;
(
    input  logic        clk,
    input  sample_req_t req,
    output logic [7:0]  rd_data
);

    logic [7:0] mem [SAMPLE_MEMORY_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### rtl/core/svm_voice_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svm_voice_ram
// Per-voice state table, single port, registered read.
// ----------------------------------------------------------------------------
module svm_voice_ram
    import svm_pkg::*;
(
    input  logic         clk,
    input  voice_req_t   req,
    output voice_entry_t rd_data
);

    voice_entry_t mem [VOICE_COUNT];
    voice_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### rtl/core/svm_step_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svm_step_div
// Three-stage divider for the 16.16 playback step: reciprocal estimate,
// remainder, then one correction.
// ----------------------------------------------------------------------------
module svm_step_div
    import svm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [15:0]       rate,
    output logic              done,
    output logic [STEP_W-1:0] quotient
);

    logic                   prod_vld_reg;
    logic                   rem_vld_reg;
    logic                   done_reg;
    logic [15:0]            rate_reg;
    logic [STEP_PROD_W-1:0] prod_reg;
    logic [STEP_W-1:0]      est_reg;
    logic [STEP_REM_W-1:0]  rem_reg;
    logic [STEP_W-1:0]      quo_reg;
    logic [STEP_PROD_W-1:0] prod;
    logic [STEP_W-1:0]      est;
    logic [DIVIDEND_W-1:0]  back;
    logic [DIVIDEND_W-1:0]  rem_full;

    // The estimate is low by at most one, so the remainder stays below twice
    // the output rate and a single compare finishes the quotient.
    always_comb
    begin
        prod     = STEP_PROD_W'(rate) * STEP_PROD_W'(STEP_RECIP);
        est      = prod_reg[STEP_SHIFT +: STEP_W];
        back     = DIVIDEND_W'(est) * DIVIDEND_W'(OUTPUT_RATE);
        rem_full = DIVIDEND_W'({rate_reg, 16'h0000}) - back;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            rem_vld_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= start;
            rem_vld_reg  <= prod_vld_reg;
            done_reg     <= rem_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rate_reg <= rate;
            prod_reg <= prod;
        end
        est_reg <= est;
        rem_reg <= rem_full[STEP_REM_W-1:0];
        quo_reg <= est_reg + STEP_W'(rem_reg >= STEP_REM_W'(OUTPUT_RATE));
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

### rtl/core/svm_div127.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svm_div127
// Two-lane floor division by 127: reciprocal estimate, then one correction.
// ----------------------------------------------------------------------------
module svm_div127
    import svm_pkg::*;
(
    input  logic                      clk,
    input  logic [1:0][DIV_MAG_W-1:0] mag,
    output logic [1:0][QUOT_W-1:0]    quot
);

    logic [1:0][DIV_MAG_W-1:0]         mag_s1_reg;
    logic [1:0][DIV_MAG_W-1:0]         mag_s2_reg;
    logic [1:0][QUOT_W-1:0]            est_reg;
    logic [1:0][DIV_MAG_W+RECIP_W-1:0] prod;
    logic [1:0][DIV_REM_W-1:0]         rem;

    // The estimate is low by at most one; the remainder check fixes that.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            prod[i] = (DIV_MAG_W + RECIP_W)'(mag_s1_reg[i])
                    * (DIV_MAG_W + RECIP_W)'(DIV_RECIP);
            rem[i]  = DIV_REM_W'(mag_s2_reg[i])
                    - DIV_REM_W'(est_reg[i]) * DIV_REM_W'(FULL_GAIN);
            quot[i] = est_reg[i] + QUOT_W'(rem[i] >= DIV_REM_W'(FULL_GAIN));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            mag_s1_reg[i] <= mag[i];
            mag_s2_reg[i] <= mag_s1_reg[i];
            est_reg[i]    <= prod[i][DIV_SHIFT +: QUOT_W];
        end
    end

endmodule
`default_nettype wire

### rtl/core/sample_voice_mixer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sample_voice_mixer_unit
// Eight-voice 8-bit PCM mixer with 16.16 resampling into a saturated
// signed 16-bit stereo frame, plus sample writes and voice control.
// ----------------------------------------------------------------------------
// Flow: write, stop, rejected start and unknown actions finish in dispatch;
//   volume/pan passes two gain states and a write-back state; an accepted
//   start waits for the step divider. A mix walks the voice table by
//   read-modify-write: a playing voice passes scan, check, multiply, two
//   divide states and accumulate; one that ends, scan and check; an idle
//   one, scan only. One word at a time; busy stays high until the result word.
// Reset clears the playing bits and control state; the sample memory holds
//   nothing defined until written, and there is no clearing pass.
// The result strobe (done) lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module sample_voice_mixer_unit
    import svm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  command_t command,
    output logic     done,
    output result_t  result
);

    // One-hot sequencer states.
    typedef enum logic [11:0] {
        ST_IDLE       = 12'b000000000001,
        ST_DISPATCH   = 12'b000000000010,
        ST_START_WAIT = 12'b000000000100,
        ST_GAIN_A     = 12'b000000001000,
        ST_GAIN_B     = 12'b000000010000,
        ST_VP_WRITE   = 12'b000000100000,
        ST_MIX_SCAN   = 12'b000001000000,
        ST_MIX_CHECK  = 12'b000010000000,
        ST_MIX_MUL    = 12'b000100000000,
        ST_MIX_DIV1   = 12'b001000000000,
        ST_MIX_DIV2   = 12'b010000000000,
        ST_MIX_ACC    = 12'b100000000000
    } state_t;

    localparam logic signed [17:0] SUM_HI = 18'(ACC_MAX);
    localparam logic signed [17:0] SUM_LO = 18'(ACC_MIN);

    state_t                   state_reg, state_next;
    command_t                 cmd_reg, cmd_next;
    logic [VOICE_COUNT-1:0]   playing_reg, playing_next;
    logic [VOICE_CNT_W-1:0]   vidx_reg, vidx_next;
    logic signed [15:0]       acc_l_reg, acc_l_next;
    logic signed [15:0]       acc_r_reg, acc_r_next;
    logic signed [PROD_W-1:0] prod_l_reg, prod_l_next;
    logic signed [PROD_W-1:0] prod_r_reg, prod_r_next;
    logic [GPROD_W-1:0]       gprod_l_reg, gprod_l_next;
    logic [GPROD_W-1:0]       gprod_r_reg, gprod_r_next;
    result_t                  result_reg, result_next;
    logic                     done_reg, done_next;

    sample_req_t              sample_req;
    logic [7:0]               sample_rd;
    voice_req_t               voice_req;
    voice_entry_t             voice_rd;

    logic                     step_start;
    logic                     step_done;
    logic [STEP_W-1:0]        step_q;

    logic [1:0][DIV_MAG_W-1:0] div_mag;
    logic [1:0][QUOT_W-1:0]    div_quot;

    logic [VOICE_IDX_W-1:0]   cmd_voice;
    logic [VOICE_IDX_W-1:0]   vidx_sel;
    logic                     voice_ok;
    logic [16:0]              lump_sat;
    logic                     start_reject;
    logic [7:0]               sep_clamp;
    logic [7:0]               pan_left;
    logic [14:0]              gfull_l, gfull_r;
    logic signed [8:0]        centered;
    logic signed [16:0]       sample_word;
    logic signed [24:0]       prod_l_full, prod_r_full;
    logic [PROD_W-1:0]        neg_l, neg_r;
    logic signed [17:0]       contrib_l, contrib_r;
    logic signed [17:0]       sum_l, sum_r;
    logic                     finish;
    logic                     mix_done;
    logic                     reject;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] x);
        logic signed [15:0] y;
        if (x > SUM_HI)
        begin
            y = 16'(ACC_MAX);
        end
        else if (x < SUM_LO)
        begin
            y = 16'(ACC_MIN);
        end
        else
        begin
            y = x[15:0];
        end
        return y;
    endfunction

    svm_sample_ram u_sample_ram (
        .clk     (clk),
        .req     (sample_req),
        .rd_data (sample_rd)
    );

    svm_voice_ram u_voice_ram (
        .clk     (clk),
        .req     (voice_req),
        .rd_data (voice_rd)
    );

    svm_step_div u_step_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (step_start),
        .rate     (cmd_reg.sample_rate),
        .done     (step_done),
        .quotient (step_q)
    );

    svm_div127 u_div127 (
        .clk  (clk),
        .mag  (div_mag),
        .quot (div_quot)
    );

    // Command decode and start checks, all from the captured command word.
    always_comb
    begin
        cmd_voice    = VOICE_IDX_W'(cmd_reg.voice);
        voice_ok     = (int'(cmd_reg.voice) < VOICE_COUNT);
        lump_sat     = (cmd_reg.lump_length > 17'(LUMP_MAX)) ? 17'(LUMP_MAX)
                                                             : cmd_reg.lump_length;
        start_reject = (cmd_reg.format_tag != 16'(WAVE_TAG))
                    || (lump_sat < 17'(MIN_LUMP))
                    || (cmd_reg.data_length > (32'(lump_sat) - 32'(HEADER_LEN)))
                    || (cmd_reg.data_length <= 32'(MIN_DATA))
                    || !voice_ok;

        // Pan gains are volume * pan / 254, taken as (product / 2) / 127.
        sep_clamp    = (cmd_reg.separation > 8'(PAN_MAX)) ? 8'(PAN_MAX)
                                                          : cmd_reg.separation;
        pan_left     = 8'(PAN_MAX) - sep_clamp;
        gfull_l      = 15'(cmd_reg.volume) * 15'(pan_left);
        gfull_r      = 15'(cmd_reg.volume) * 15'(sep_clamp);
    end

    // Mix datapath: centered sample scaled by 256, times gain, then / 127
    // with truncation toward zero (divide the magnitude, restore the sign).
    always_comb
    begin
        vidx_sel    = vidx_reg[VOICE_IDX_W-1:0];
        centered    = $signed(9'({1'b0, sample_rd}) - 9'(SAMPLE_BIAS));
        sample_word = $signed({centered, 8'h00});
        prod_l_full = sample_word * $signed({1'b0, voice_rd.left_gain});
        prod_r_full = sample_word * $signed({1'b0, voice_rd.right_gain});
        neg_l       = -prod_l_reg;
        neg_r       = -prod_r_reg;

        // The divide lanes serve the mixer in its first divide cycle and the
        // gain calculation at every other time.
        if (state_reg == ST_MIX_DIV1)
        begin
            div_mag[0] = prod_l_reg[PROD_W-1] ? neg_l[DIV_MAG_W-1:0]
                                              : prod_l_reg[DIV_MAG_W-1:0];
            div_mag[1] = prod_r_reg[PROD_W-1] ? neg_r[DIV_MAG_W-1:0]
                                              : prod_r_reg[DIV_MAG_W-1:0];
        end
        else
        begin
            div_mag[0] = DIV_MAG_W'(gprod_l_reg);
            div_mag[1] = DIV_MAG_W'(gprod_r_reg);
        end

        contrib_l = prod_l_reg[PROD_W-1] ? -$signed({2'b00, div_quot[0]})
                                         : $signed({2'b00, div_quot[0]});
        contrib_r = prod_r_reg[PROD_W-1] ? -$signed({2'b00, div_quot[1]})
                                         : $signed({2'b00, div_quot[1]});
        sum_l     = $signed({{2{acc_l_reg[15]}}, acc_l_reg}) + contrib_l;
        sum_r     = $signed({{2{acc_r_reg[15]}}, acc_r_reg}) + contrib_r;
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        playing_next = playing_reg;
        vidx_next    = vidx_reg;
        acc_l_next   = acc_l_reg;
        acc_r_next   = acc_r_reg;
        prod_l_next  = prod_l_reg;
        prod_r_next  = prod_r_reg;
        gprod_l_next = gprod_l_reg;
        gprod_r_next = gprod_r_reg;
        result_next  = result_reg;
        done_next    = 1'b0;
        sample_req   = '0;
        voice_req    = '0;
        step_start   = 1'b0;
        finish       = 1'b0;
        mix_done     = 1'b0;
        reject       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = command;
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                gprod_l_next = gfull_l[14:1];
                gprod_r_next = gfull_r[14:1];
                case (cmd_reg.action)
                    ACT_WRITE:
                    begin
                        sample_req.wr_en = 1'b1;
                        sample_req.addr  = SAMPLE_ADDR_W'(cmd_reg.address);
                        sample_req.wdata = cmd_reg.sample_byte;
                        finish           = 1'b1;
                    end
                    ACT_START:
                    begin
                        if (start_reject)
                        begin
                            reject = 1'b1;
                            finish = 1'b1;
                        end
                        else
                        begin
                            step_start = 1'b1;
                            state_next = ST_START_WAIT;
                        end
                    end
                    ACT_VOLPAN:
                    begin
                        if (voice_ok)
                        begin
                            voice_req.rd_en = 1'b1;
                            voice_req.addr  = cmd_voice;
                            state_next      = ST_GAIN_A;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                    ACT_STOP:
                    begin
                        if (voice_ok)
                        begin
                            playing_next[cmd_voice] = 1'b0;
                        end
                        finish = 1'b1;
                    end
                    ACT_MIX:
                    begin
                        acc_l_next = '0;
                        acc_r_next = '0;
                        vidx_next  = '0;
                        state_next = ST_MIX_SCAN;
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
            end

            // The gain lanes settle in the same cycle that the step comes out.
            ST_START_WAIT:
            begin
                if (step_done)
                begin
                    voice_req.wr_en              = 1'b1;
                    voice_req.addr               = cmd_voice;
                    voice_req.wdata.base         = cmd_reg.address;
                    voice_req.wdata.sample_count =
                        16'(cmd_reg.data_length - 32'(COUNT_SKIP));
                    voice_req.wdata.position     = '0;
                    voice_req.wdata.step         = (step_q == '0) ? STEP_W'(ONE_STEP)
                                                                  : step_q;
                    voice_req.wdata.left_gain    = 7'(div_quot[0]);
                    voice_req.wdata.right_gain   = 7'(div_quot[1]);
                    playing_next[cmd_voice]      = 1'b1;
                    finish                       = 1'b1;
                end
            end

            ST_GAIN_A:
            begin
                state_next = ST_GAIN_B;
            end

            ST_GAIN_B:
            begin
                state_next = ST_VP_WRITE;
            end

            ST_VP_WRITE:
            begin
                voice_req.wr_en            = 1'b1;
                voice_req.addr             = cmd_voice;
                voice_req.wdata            = voice_rd;
                voice_req.wdata.left_gain  = 7'(div_quot[0]);
                voice_req.wdata.right_gain = 7'(div_quot[1]);
                finish                     = 1'b1;
            end

            ST_MIX_SCAN:
            begin
                if (vidx_reg == VOICE_CNT_W'(VOICE_COUNT))
                begin
                    mix_done = 1'b1;
                    finish   = 1'b1;
                end
                else if (playing_reg[vidx_sel])
                begin
                    voice_req.rd_en = 1'b1;
                    voice_req.addr  = vidx_sel;
                    state_next      = ST_MIX_CHECK;
                end
                else
                begin
                    vidx_next = vidx_reg + 1'b1;
                end
            end

            // A voice at the end of its data stops here and adds nothing;
            // otherwise fetch its byte and write back the advanced cursor.
            ST_MIX_CHECK:
            begin
                if (voice_rd.position[31:16] >= voice_rd.sample_count)
                begin
                    playing_next[vidx_sel] = 1'b0;
                    vidx_next              = vidx_reg + 1'b1;
                    state_next             = ST_MIX_SCAN;
                end
                else
                begin
                    sample_req.rd_en         = 1'b1;
                    sample_req.addr          = SAMPLE_ADDR_W'(32'(voice_rd.base)
                                             + 32'(SAMPLE_SKIP)
                                             + 32'(voice_rd.position[31:16]));
                    voice_req.wr_en          = 1'b1;
                    voice_req.addr           = vidx_sel;
                    voice_req.wdata          = voice_rd;
                    voice_req.wdata.position = voice_rd.position
                                             + 32'(voice_rd.step);
                    state_next               = ST_MIX_MUL;
                end
            end

            ST_MIX_MUL:
            begin
                prod_l_next = prod_l_full[PROD_W-1:0];
                prod_r_next = prod_r_full[PROD_W-1:0];
                state_next  = ST_MIX_DIV1;
            end

            ST_MIX_DIV1:
            begin
                state_next = ST_MIX_DIV2;
            end

            ST_MIX_DIV2:
            begin
                state_next = ST_MIX_ACC;
            end

            // Saturate after every voice, in voice order.
            ST_MIX_ACC:
            begin
                acc_l_next = sat16(sum_l);
                acc_r_next = sat16(sum_r);
                vidx_next  = vidx_reg + 1'b1;
                state_next = ST_MIX_SCAN;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next                 = ST_IDLE;
            done_next                  = 1'b1;
            result_next.left_sample    = mix_done ? acc_l_reg : '0;
            result_next.right_sample   = mix_done ? acc_r_reg : '0;
            result_next.start_status   = reject;
            result_next.active_voices  = '0;
            for (int i = 0; i < FIELD_VOICES; i++)
            begin
                result_next.active_voices[i] = playing_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            playing_reg <= '0;
            vidx_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            playing_reg <= playing_next;
            vidx_reg    <= vidx_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        acc_l_reg   <= acc_l_next;
        acc_r_reg   <= acc_r_next;
        prod_l_reg  <= prod_l_next;
        prod_r_reg  <= prod_r_next;
        gprod_l_reg <= gprod_l_next;
        gprod_r_reg <= gprod_r_next;
        result_reg  <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

### test/tb_sample_voice_mixer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sample_voice_mixer_unit
// Self-checking bench for the eight-voice sample mixer. Command words are
// driven through the start/busy handshake. A scoreboard keeps its own copy of
// the voice table and the sample memory and predicts the result word of each
// accepted command. Every strobed result word is compared field by field
// with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sample_voice_mixer_unit;
    import svm_pkg::*;

    // Actions 5..7 have no meaning. The block must leave all state alone for them.
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    localparam int RANDOM_WORDS  = 800;
    localparam int CYCLE_LIMIT   = 2500000;
    localparam int SETTLE_CYCLES = 80;

    // ------------------------------------------------------------------------
    // Scoreboard: a shadow of the voice table plus the sample memory, and the
    // queue of result words that are still owed by the block.
    // ------------------------------------------------------------------------
    class voice_mix_board;
        logic [7:0]  pcm_mem [0:SAMPLE_MEMORY_DEPTH-1];
        bit          pcm_written [0:SAMPLE_MEMORY_DEPTH-1];
        bit          lane_on [VOICE_COUNT];
        logic [15:0] lane_base [VOICE_COUNT];
        logic [31:0] lane_len [VOICE_COUNT];
        logic [31:0] lane_cursor [VOICE_COUNT];
        logic [31:0] lane_inc [VOICE_COUNT];
        int          gain_l [VOICE_COUNT];
        int          gain_r [VOICE_COUNT];
        result_t     pending_results [$];
        int          mismatch_count;

        function int pending_count();
            return pending_results.size();
        endfunction

        // Byte that voice v fetches at its next frame. Addresses wrap at 64K.
        function logic [15:0] fetch_addr(int v);
            return 16'(lane_base[v] + SAMPLE_SKIP + (lane_cursor[v] >> 16));
        endfunction

        // True when voice v still has samples left, so the next mix reads memory.
        function bit reads_now(int v);
            return lane_on[v] && ((lane_cursor[v] >> 16) < lane_len[v]);
        endfunction

        // The bench must never make the block read a byte that was never
        // written. This finds such a byte ahead of the next mix, if one exists.
        function bit missing_byte(output logic [15:0] addr);
            int v;
            addr = '0;
            for (v = 0; v < VOICE_COUNT; v++)
            begin
                if (reads_now(v) && !pcm_written[fetch_addr(v)])
                begin
                    addr = fetch_addr(v);
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function int sat16(int x);
            if (x > ACC_MAX)
                return ACC_MAX;
            if (x < ACC_MIN)
                return ACC_MIN;
            return x;
        endfunction

        // Pan law: a separation above 254 acts as 254.
        function void apply_gains(int v, logic [6:0] vol, logic [7:0] sep);
            int pan;
            pan = (sep > PAN_MAX) ? PAN_MAX : int'(sep);
            gain_l[v] = (int'(vol) * (PAN_MAX - pan)) / PAN_MAX;
            gain_r[v] = (int'(vol) * pan) / PAN_MAX;
        endfunction

        // Header checks, then the voice is loaded. Returns 1 when the start is accepted.
        function bit accept_start(command_t c);
            longint lump;
            longint dlen;
            longint step;
            lump = c.lump_length;
            if (lump > LUMP_MAX)
                lump = LUMP_MAX;
            dlen = c.data_length;
            if (c.format_tag != WAVE_TAG || lump < MIN_LUMP || dlen > lump - HEADER_LEN ||
                dlen <= MIN_DATA)
                return 1'b0;
            step = (longint'(c.sample_rate) << 16) / OUTPUT_RATE;
            if (step == 0)
                step = ONE_STEP;
            lane_base[c.voice]   = c.address;
            lane_len[c.voice]    = 32'(dlen - COUNT_SKIP);
            lane_cursor[c.voice] = '0;
            lane_inc[c.voice]    = 32'(step);
            apply_gains(c.voice, c.volume, c.separation);
            lane_on[c.voice]     = 1'b1;
            return 1'b1;
        endfunction

        // One stereo frame. The sum saturates after each voice, in voice order.
        // A voice whose cursor has run past its length drops out silently.
        function void mix_frame(output int acc_l, output int acc_r);
            int v;
            int pcm;
            acc_l = 0;
            acc_r = 0;
            for (v = 0; v < VOICE_COUNT; v++)
            begin
                if (lane_on[v])
                begin
                    if (!reads_now(v))
                        lane_on[v] = 1'b0;
                    else
                    begin
                        pcm = (int'(pcm_mem[fetch_addr(v)]) - SAMPLE_BIAS) * 256;
                        acc_l = sat16(acc_l + (pcm * gain_l[v]) / FULL_GAIN);
                        acc_r = sat16(acc_r + (pcm * gain_r[v]) / FULL_GAIN);
                        lane_cursor[v] = lane_cursor[v] + lane_inc[v];
                    end
                end
            end
        endfunction

        // Called once for each accepted command word.
        function void note_command(command_t c);
            result_t r;
            int      acc_l;
            int      acc_r;
            int      v;
            r = '0;
            case (c.action)
                ACT_WRITE:
                begin
                    pcm_mem[c.address]     = c.sample_byte;
                    pcm_written[c.address] = 1'b1;
                end
                ACT_START:  r.start_status = !accept_start(c);
                ACT_VOLPAN: apply_gains(c.voice, c.volume, c.separation);
                ACT_STOP:   lane_on[c.voice] = 1'b0;
                ACT_MIX:
                begin
                    mix_frame(acc_l, acc_r);
                    r.left_sample  = 16'(acc_l);
                    r.right_sample = 16'(acc_r);
                end
                default: ;
            endcase
            for (v = 0; v < FIELD_VOICES; v++)
                r.active_voices[v] = lane_on[v];
            pending_results.push_back(r);
        endfunction

        // Called for each strobed result word.
        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with nothing expected, actual %h", $time, got);
                mismatch_count++;
                return;
            end
            want = pending_results.pop_front();
            if (got.left_sample !== want.left_sample)
            begin
                $display("%0t: left_sample expected %0d actual %0d",
                         $time, want.left_sample, got.left_sample);
                mismatch_count++;
            end
            if (got.right_sample !== want.right_sample)
            begin
                $display("%0t: right_sample expected %0d actual %0d",
                         $time, want.right_sample, got.right_sample);
                mismatch_count++;
            end
            if (got.active_voices !== want.active_voices)
            begin
                $display("%0t: active_voices expected %b actual %b",
                         $time, want.active_voices, got.active_voices);
                mismatch_count++;
            end
            if (got.start_status !== want.start_status)
            begin
                $display("%0t: start_status expected %b actual %b",
                         $time, want.start_status, got.start_status);
                mismatch_count++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block itself. All inputs have known values from
    // time zero, so the block never sees an X on start or on the command word.
    // ------------------------------------------------------------------------
    logic     clk     = 1'b0;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    command_t command = '0;
    logic     busy;
    logic     done;
    result_t  result;

    voice_mix_board board;
    int             words_sent  = 0;
    int             cycle_count = 0;
    bit             burst_mode  = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sample_voice_mixer_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .done    (done),
        .result  (result)
    );

    // The strobe cannot be held off, so every edge with done high delivers a
    // word. Values are read before this edge's updates land, which is exactly
    // what the edge accepts.
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(result);
    end

    // Watchdog. The limit is several times the slowest legal run: every word
    // a full eight-voice mix, plus the longest sender gap.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------------

    // Every field is filled with random bits. The fields that an action ignores
    // still toggle on the port this way.
    function automatic command_t random_command();
        command_t c;
        c.action      = 3'($urandom);
        c.voice       = 3'($urandom);
        c.address     = 16'($urandom);
        c.sample_byte = 8'($urandom);
        c.format_tag  = 16'($urandom);
        c.sample_rate = 16'($urandom);
        c.data_length = $urandom;
        c.lump_length = 17'($urandom);
        c.volume      = 7'($urandom);
        c.separation  = 8'($urandom);
        return c;
    endfunction

    // Full-scale bytes come up often, so the saturation paths get exercised.
    function automatic logic [7:0] draw_sample_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // A header that passes every check. Most sounds are short, so voices run
    // out and free up often. About one in ten uses a long lump, and may go
    // past the 64K saturation point.
    function automatic command_t wellformed_start();
        command_t c;
        int       eff_lump;
        c = random_command();
        c.action     = ACT_START;
        c.format_tag = 16'(WAVE_TAG);
        if ($urandom_range(0, 9) == 0)
            c.lump_length = 17'($urandom_range(57, 131071));
        else
            c.lump_length = 17'($urandom_range(57, 300));
        eff_lump = (c.lump_length > LUMP_MAX) ? LUMP_MAX : int'(c.lump_length);
        c.data_length = $urandom_range(MIN_DATA + 1, eff_lump - HEADER_LEN);
        if ($urandom_range(0, 1) == 1)
            c.volume = 7'(FULL_GAIN);
        if ($urandom_range(0, 1) == 1)
            c.sample_rate = 16'($urandom_range(0, 22050));
        return c;
    endfunction

    // A header that breaks one rule, or is pure noise.
    function automatic command_t broken_start();
        command_t c;
        c = wellformed_start();
        case ($urandom_range(0, 4))
            0: c.format_tag = c.format_tag ^ 16'($urandom_range(1, 65535));
            1: c.lump_length = 17'($urandom_range(0, MIN_LUMP - 1));
            // A data length equal to the lump length is always past lump minus 8.
            2: c.data_length = 32'(c.lump_length);
            3: c.data_length = $urandom_range(0, MIN_DATA);
            default:
            begin
                c = random_command();
                c.action = ACT_START;
            end
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Driving tasks. Each one is entered right after a rising edge. start goes
    // low only when a gap is drawn or the results are drained, so a back-to-back
    // word never sees start lowered and raised in the same step.
    // ------------------------------------------------------------------------
    task automatic send_command(input command_t c);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        command <= c;
        // The word is taken at the first edge where busy was low.
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_command(c);
        words_sent++;
    endtask

    // Before each mix, every byte that the playing voices are about to fetch and
    // that was never written is written first. The new bytes are random, so memory
    // reads stay defined while their content is still random.
    task automatic send_mix();
        command_t    c;
        logic [15:0] hole;
        while (board.missing_byte(hole))
        begin
            c = random_command();
            c.action      = ACT_WRITE;
            c.address     = hole;
            c.sample_byte = draw_sample_byte();
            send_command(c);
        end
        c = random_command();
        c.action = ACT_MIX;
        send_command(c);
    endtask

    task automatic send_start(input logic [2:0] v, input logic [15:0] base,
                              input logic [15:0] tag, input logic [15:0] rate,
                              input logic [31:0] dlen, input logic [16:0] llen,
                              input logic [6:0] vol, input logic [7:0] sep);
        command_t c;
        c = random_command();
        c.action      = ACT_START;
        c.voice       = v;
        c.address     = base;
        c.format_tag  = tag;
        c.sample_rate = rate;
        c.data_length = dlen;
        c.lump_length = llen;
        c.volume      = vol;
        c.separation  = sep;
        send_command(c);
    endtask

    task automatic send_volpan(input logic [2:0] v, input logic [6:0] vol,
                               input logic [7:0] sep);
        command_t c;
        c = random_command();
        c.action     = ACT_VOLPAN;
        c.voice      = v;
        c.volume     = vol;
        c.separation = sep;
        send_command(c);
    endtask

    task automatic send_action(input logic [2:0] act, input logic [2:0] v);
        command_t c;
        c = random_command();
        c.action = act;
        c.voice  = v;
        send_command(c);
    endtask

    task automatic send_write(input logic [15:0] addr, input logic [7:0] value);
        command_t c;
        c = random_command();
        c.action      = ACT_WRITE;
        c.address     = addr;
        c.sample_byte = value;
        send_command(c);
    endtask

    // Stop sending and wait until every owed result word has arrived.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (board.pending_count() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int  sel;
        bit  drained_once;
        drained_once = 1'b0;
        board = new;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Start rejects: a bad tag, a lump shorter than 40 bytes, a 40-byte
        // lump that cannot hold any legal data length, a data length one past
        // lump minus 8, and a data length of exactly 48.
        send_start(3'd0, 16'd1000, 16'd2, 16'd11025, 32'd100, 17'd200, 7'd127, 8'd128);
        send_start(3'd0, 16'd1000, 16'(WAVE_TAG), 16'd11025, 32'd49, 17'd39, 7'd127, 8'd128);
        send_start(3'd0, 16'd1000, 16'(WAVE_TAG), 16'd11025, 32'd49, 17'd40, 7'd127, 8'd128);
        send_start(3'd0, 16'd1000, 16'(WAVE_TAG), 16'd11025, 32'd93, 17'd100, 7'd127, 8'd128);
        send_start(3'd0, 16'd1000, 16'(WAVE_TAG), 16'd11025, 32'd48, 17'd100, 7'd127, 8'd128);

        // Voice 0 runs at the top rate. Its data length sits exactly at lump
        // minus 8. Its fetches run up to address 65535, and it ends after a
        // few frames. Voice 1 has rate zero, which forces the unit step, a
        // saturated oversize lump, the longest data length and full right pan.
        // Voice 2 plays at unit rate, full left, so that it can saturate
        // together with voice 0.
        send_start(3'd0, 16'd65500, 16'(WAVE_TAG), 16'd65535, 32'd49, 17'd57, 7'd127, 8'd0);
        send_start(3'd1, 16'd100, 16'(WAVE_TAG), 16'd0, 32'd65528, 17'd131071, 7'd127, 8'd255);
        send_start(3'd2, 16'h8000, 16'(WAVE_TAG), 16'd11025, 32'd60, 17'd68, 7'd127, 8'd0);
        send_write(16'hFFFF, 8'hFF);
        send_write(16'h0000, 8'h00);
        repeat (5) send_mix();

        // Silence voice 2, then pan it hard right at full volume.
        send_volpan(3'd2, 7'd0, 8'd0);
        send_mix();
        send_volpan(3'd2, 7'd127, 8'd254);
        send_mix();

        send_action(ACT_STOP, 3'd1);
        send_action(ACT_SPARE_LO, 3'd1);
        send_action(ACT_SPARE_LO + 3'd1, 3'd2);
        send_action(ACT_SPARE_HI, 3'd3);
        send_mix();

        // Random part. Mixes dominate, so voices keep playing to their end.
        // Well-formed starts keep the voice table busy. Malformed starts,
        // pan changes, stops, stray writes and the spare actions are mixed in.
        // The sender toggles between random gaps and back-to-back bursts.
        while (words_sent < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 39) == 0)
                burst_mode = !burst_mode;
            if ((!drained_once && words_sent >= RANDOM_WORDS / 2) ||
                $urandom_range(0, 99) == 0)
            begin
                drain_results();
                drained_once = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 9)
                send_command(wellformed_start());
            else if (sel < 13)
                send_command(broken_start());
            else if (sel < 18)
                send_volpan(3'($urandom), 7'($urandom), 8'($urandom));
            else if (sel < 21)
                send_action(ACT_STOP, 3'($urandom));
            else if (sel < 23)
                send_action(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), 3'($urandom));
            else if (sel < 33)
                send_write(16'($urandom), draw_sample_byte());
            else
                send_mix();
        end

        // Wait for the last words, then let the clock run on for a settle period so
        // that a stray extra word can still show up.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (board.mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
